/* rtl/bevq_pkg.sv */
// Package for the bounded event queue: beat structs, command and register codes,
// cell operation codes and default sizes. No dependencies.
package bevq_pkg;

   localparam int BEVQ_DEPTH     = 64;
   localparam int BEVQ_DATA_BITS = 32;

   localparam logic [1:0] KIND_ENQUEUE = 2'd0;
   localparam logic [1:0] KIND_DEQUEUE = 2'd1;
   localparam logic [1:0] KIND_FLUSH   = 2'd2;

   localparam logic CSR_CAPACITY  = 1'b0;
   localparam logic CSR_ACCEPTING = 1'b1;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_LOAD
   } cell_op_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  event_class;
      logic [31:0] event_data;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        dropped;
      logic        dropped_class;
      logic        head_valid;
      logic [1:0]  head_class;
      logic [31:0] head_data;
      logic [6:0]  fill_level;
      logic [31:0] drop_total;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic advance;
   } scan_ctrl_type;

endpackage

/* rtl/bevq_cell.sv */
// One queue entry: holds, takes its neighbour's entry or loads a new event.
// Depends on bevq_pkg.
module bevq_cell #(
   parameter int DATA_BITS = bevq_pkg::BEVQ_DATA_BITS
) (
   input  logic                   clock,
   input  bevq_pkg::cell_op_type  op,
   input  logic [1:0]             next_class,
   input  logic [DATA_BITS-1:0]   next_data,
   input  logic [1:0]             new_class,
   input  logic [DATA_BITS-1:0]   new_data,
   output logic [1:0]             cell_class,
   output logic [DATA_BITS-1:0]   cell_data
);
   import bevq_pkg::*;

   logic [1:0]           class_ff, class_in;
   logic [DATA_BITS-1:0] data_ff, data_in;

   always_comb begin
      unique case (op)
         CELL_SHIFT: begin
            class_in = next_class;
            data_in  = next_data;
         end
         CELL_LOAD: begin
            class_in = new_class;
            data_in  = new_data;
         end
         default: begin
            class_in = class_ff;
            data_in  = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      class_ff <= class_in;
      data_ff  <= data_in;
   end

   assign cell_class = class_ff;
   assign cell_data  = data_ff;

endmodule

/* rtl/bevq_scan.sv */
// Prefix search for the oldest tick or bar: one doubling step a cycle while advance is held.
// Depends on bevq_pkg.
module bevq_scan #(
   parameter int DEPTH = bevq_pkg::BEVQ_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bevq_pkg::scan_ctrl_type  ctrl,
   input  logic [DEPTH-1:0]         market,
   input  logic [DEPTH-1:0]         market_class,
   output logic [DEPTH-1:0]         upto,
   output logic                     found,
   output logic                     found_class,
   output logic                     done
);
   import bevq_pkg::*;

   localparam int SW     = DEPTH + 1;
   localparam int STEPS  = $clog2(SW);
   localparam int STEP_W = $clog2(STEPS);

   logic [SW-1:0]     seen_ff, seen_in, cls_ff, cls_in, seen_sh, cls_sh;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;

   always_comb begin
      seen_sh = seen_ff << (SW'(1) << step_ff);
      cls_sh  = cls_ff << (SW'(1) << step_ff);
      seen_in = seen_ff;
      cls_in  = cls_ff;
      step_in = step_ff;
      done_in = done_ff;
      if (ctrl.load) begin
         seen_in = {market, 1'b0};
         cls_in  = {market_class, 1'b0};
         step_in = '0;
         done_in = 1'b0;
      end else if (ctrl.advance && !done_ff) begin
         seen_in = seen_ff | seen_sh;
         for (int i = 0; i < SW; i++) begin
            cls_in[i] = seen_sh[i] ? cls_sh[i] : cls_ff[i];
         end
         step_in = step_ff + STEP_W'(1);
         done_in = (step_ff == STEP_W'(STEPS - 1));
      end
   end

   always_ff @(posedge clock) begin
      seen_ff <= seen_in;
      cls_ff  <= cls_in;
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   assign upto        = seen_ff[SW-1:1];
   assign found       = seen_ff[SW-1];
   assign found_class = cls_ff[SW-1];
   assign done        = done_ff;

endmodule

/* rtl/bounded_event_queue_drop_oldest_market.sv */
// Bounded event queue with drop-oldest of ticks and bars, built as a row of entry cells.
// An accepted item goes to EXEC, or first through SCAN when an enqueue meets a full queue
// while accepting, where the doubling prefix search over the cells runs; EXEC registers the result.
// A new item is taken only when idle; busy is high while an item is in flight.
// Reset: synchronous, returns to idle and clears strobe, count, drop counter, capacity and accepting; cells keep data.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module bounded_event_queue_drop_oldest_market #(
   parameter int DEPTH     = bevq_pkg::BEVQ_DEPTH,
   parameter int DATA_BITS = bevq_pkg::BEVQ_DATA_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bevq_pkg::req_type req_data,
   output logic              rsp_strobe,
   output bevq_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [6:0]        csr_wdata
);
   import bevq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0]       state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      drops_ff, drops_in;
   logic [6:0]       capacity_ff;
   logic             accepting_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             strobe_ff, strobe_in;

   logic [1:0]           cell_class [DEPTH];
   logic [DATA_BITS-1:0] cell_data [DEPTH];
   cell_op_type          cell_op [DEPTH];
   logic [DEPTH-1:0]     market, market_class, upto;
   logic                 found, found_class, scan_done;
   scan_ctrl_type        scan_ctrl;

   logic [63:0]          new_wide, head_wide;
   logic [DATA_BITS-1:0] new_data;
   logic [CMP_W-1:0]     cap_x, depth_x, eff_cap, count_x;
   logic                 full, enq_ok, do_drop, do_store, do_deq, exec, accept;
   logic [CNT_W-1:0]     count_after;

   assign accept   = start && (state_ff == ST_IDLE);
   assign exec     = (state_ff == ST_EXEC);
   assign new_wide = 64'(req_ff.event_data);
   assign new_data = new_wide[DATA_BITS-1:0];

   assign cap_x   = CMP_W'(capacity_ff);
   assign depth_x = CMP_W'(DEPTH);
   assign eff_cap = ((capacity_ff == 7'd0) || (cap_x > depth_x)) ? depth_x : cap_x;
   assign count_x = CMP_W'(count_ff);
   assign full    = (count_x >= eff_cap);

   assign enq_ok      = (req_ff.kind == KIND_ENQUEUE) && accepting_ff;
   assign do_drop     = enq_ok && full && found;
   assign count_after = do_drop ? (count_ff - CNT_W'(1)) : count_ff;
   assign do_store    = enq_ok && (!full || found) && (CMP_W'(count_after) < depth_x);
   assign do_deq      = (req_ff.kind == KIND_DEQUEUE) && (count_ff != '0);

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic [1:0]           nxt_class;
         logic [DATA_BITS-1:0] nxt_data;

         if (gi == DEPTH - 1) begin : g_last
            assign nxt_class = cell_class[gi];
            assign nxt_data  = cell_data[gi];
         end else begin : g_mid
            assign nxt_class = cell_class[gi+1];
            assign nxt_data  = cell_data[gi+1];
         end

         assign market[gi]       = (CNT_W'(gi) < count_ff) && !cell_class[gi][1];
         assign market_class[gi] = cell_class[gi][0];

         always_comb begin
            cell_op[gi] = CELL_HOLD;
            if (exec) begin
               if (do_deq) begin
                  cell_op[gi] = CELL_SHIFT;
               end else if (do_store && (CNT_W'(gi) == count_after)) begin
                  cell_op[gi] = CELL_LOAD;
               end else if (do_drop && upto[gi]) begin
                  cell_op[gi] = CELL_SHIFT;
               end
            end
         end

         bevq_cell #(
            .DATA_BITS (DATA_BITS)
         ) u_cell (
            .clock      (clock),
            .op         (cell_op[gi]),
            .next_class (nxt_class),
            .next_data  (nxt_data),
            .new_class  (req_ff.event_class),
            .new_data   (new_data),
            .cell_class (cell_class[gi]),
            .cell_data  (cell_data[gi])
         );
      end
   endgenerate

   assign scan_ctrl.load    = accept;
   assign scan_ctrl.advance = (state_ff == ST_SCAN);

   bevq_scan #(
      .DEPTH (DEPTH)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (scan_ctrl),
      .market       (market),
      .market_class (market_class),
      .upto         (upto),
      .found        (found),
      .found_class  (found_class),
      .done         (scan_done)
   );

   assign head_wide = 64'(cell_data[0]);

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      count_in  = count_ff;
      drops_in  = drops_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ((req_data.kind == KIND_ENQUEUE) && accepting_ff && full) ?
                          ST_SCAN : ST_EXEC;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            if (req_ff.kind == KIND_FLUSH) begin
               count_in = '0;
            end else if (do_deq) begin
               count_in = count_ff - CNT_W'(1);
            end else if (do_store) begin
               count_in = count_after + CNT_W'(1);
            end else begin
               count_in = count_after;
            end
            if (do_drop && (drops_ff != 32'hFFFF_FFFF)) begin
               drops_in = drops_ff + 32'd1;
            end
            rsp_in.accepted      = do_store;
            rsp_in.dropped       = do_drop;
            rsp_in.dropped_class = do_drop && found_class;
            rsp_in.head_valid    = do_deq;
            rsp_in.head_class    = do_deq ? cell_class[0] : 2'd0;
            rsp_in.head_data     = do_deq ? head_wide[31:0] : 32'd0;
            rsp_in.fill_level    = 7'(count_in);
            rsp_in.drop_total    = drops_in;
            strobe_in            = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         drops_ff     <= '0;
         strobe_ff    <= 1'b0;
         capacity_ff  <= '0;
         accepting_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         drops_ff  <= drops_in;
         strobe_ff <= strobe_in;
         if (csr_we && (csr_index == CSR_CAPACITY)) begin
            capacity_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == CSR_ACCEPTING)) begin
            accepting_ff <= csr_wdata[0];
         end
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* tb/tb_bounded_event_queue_drop_oldest_market.sv */
// Self-checking testbench for the bounded event queue with drop-oldest of ticks and bars.
// Holds a queue mirror class that predicts every result beat; depends on bevq_pkg and the RTL.
`timescale 1ns / 1ps

module tb_bounded_event_queue_drop_oldest_market;
   import bevq_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [1:0] CLASS_TICK  = 2'd0;
   localparam logic [1:0] CLASS_BAR   = 2'd1;
   localparam logic [1:0] CLASS_ORDER = 2'd2;
   localparam logic [1:0] CLASS_TRADE = 2'd3;

   typedef struct packed {
      logic [1:0]  cls;
      logic [31:0] data;
   } held_event_type;

   class queue_mirror;
      held_event_type held[$];
      rsp_type        owed[$];
      logic [6:0]     capacity;
      logic           accepting;
      logic [31:0]    drop_count;
      int fails, commands, checked, drops, refusals, served, max_fill;

      function new();
         capacity = '0;
         accepting = 1'b0;
         drop_count = '0;
      endfunction

      function void write_register(logic idx, logic [6:0] val);
         if (idx == CSR_CAPACITY) begin
            capacity = val;
         end else begin
            accepting = val[0];
         end
      endfunction

      function int room_limit();
         int lim;
         lim = (capacity == 0) ? BEVQ_DEPTH : int'(capacity);
         if (lim > BEVQ_DEPTH) lim = BEVQ_DEPTH;
         return lim;
      endfunction

      function void apply_command(req_type cmd);
         rsp_type        r;
         held_event_type ev;
         int             pos;
         bit             room;
         r = '0;
         commands++;
         case (cmd.kind)
            KIND_ENQUEUE: begin
               if (accepting) begin
                  room = 1'b1;
                  if (held.size() >= room_limit()) begin
                     pos = -1;
                     for (int i = 0; i < held.size(); i++) begin
                        if (held[i].cls <= CLASS_BAR) begin
                           pos = i;
                           break;
                        end
                     end
                     if (pos >= 0) begin
                        r.dropped = 1'b1;
                        r.dropped_class = held[pos].cls[0];
                        held.delete(pos);
                        if (drop_count != '1) drop_count++;
                        drops++;
                     end else begin
                        room = 1'b0;
                     end
                  end
                  if (room && held.size() < BEVQ_DEPTH) begin
                     ev.cls = cmd.event_class;
                     ev.data = cmd.event_data;
                     held.insert(held.size(), ev);
                     r.accepted = 1'b1;
                  end
               end
               if (!r.accepted) refusals++;
            end
            KIND_DEQUEUE: begin
               if (held.size() > 0) begin
                  ev = held[0];
                  held.delete(0);
                  r.head_valid = 1'b1;
                  r.head_class = ev.cls;
                  r.head_data = ev.data;
                  served++;
               end
            end
            KIND_FLUSH: held.delete();
            default: ;
         endcase
         r.fill_level = 7'(held.size());
         r.drop_total = drop_count;
         if (held.size() > max_fill) max_fill = held.size();
         owed.insert(owed.size(), r);
      endfunction

      function void compare(string field, logic [31:0] exp, logic [31:0] act);
         if (exp !== act) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, exp, act);
            fails++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp;
         if (owed.size() == 0) begin
            $error("result beat with no command outstanding");
            fails++;
            return;
         end
         exp = owed[0];
         owed.delete(0);
         checked++;
         compare("accepted", 32'(exp.accepted), 32'(got.accepted));
         compare("dropped", 32'(exp.dropped), 32'(got.dropped));
         compare("dropped_class", 32'(exp.dropped_class), 32'(got.dropped_class));
         compare("head_valid", 32'(exp.head_valid), 32'(got.head_valid));
         compare("head_class", 32'(exp.head_class), 32'(got.head_class));
         compare("head_data", exp.head_data, got.head_data);
         compare("fill_level", 32'(exp.fill_level), 32'(got.fill_level));
         compare("drop_total", exp.drop_total, got.drop_total);
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic       csr_index = 1'b0;
   logic [6:0] csr_wdata = '0;

   queue_mirror mirror = new();
   bit          no_idle = 1'b0;

   bounded_event_queue_drop_oldest_market DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) mirror.check_result(rsp_data);
   end

   task automatic issue(input logic [1:0] kind, input logic [1:0] cls,
                        input logic [31:0] data);
      req_type cmd;
      int      gap;
      cmd.kind = kind;
      cmd.event_class = cls;
      cmd.event_data = data;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= cmd;
      @(posedge clock);
      while (busy) @(posedge clock);
      mirror.apply_command(cmd);
   endtask

   // hold off until every owed beat has come back, then let the block fall idle
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (mirror.owed.size() > 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [6:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      mirror.write_register(idx, val);
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_data();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom();
   endfunction

   task automatic run_phase(input int beats, input int enq_pct, input int market_pct);
      int          roll;
      logic [1:0]  cls;
      for (int n = 0; n < beats; n++) begin
         roll = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < market_pct) begin
            cls = $urandom_range(0, 1) ? CLASS_BAR : CLASS_TICK;
         end else begin
            cls = $urandom_range(0, 1) ? CLASS_TRADE : CLASS_ORDER;
         end
         if (roll < enq_pct) begin
            issue(KIND_ENQUEUE, cls, pick_data());
         end else if (roll < 96) begin
            issue(KIND_DEQUEUE, cls, pick_data());
         end else if (roll < 98) begin
            issue(KIND_FLUSH, cls, pick_data());
         end else begin
            issue(KIND_UNUSED, cls, pick_data());
         end
      end
   endtask

   initial begin
      int         enq_mix[3];
      int         market_mix[3];
      logic [6:0] caps[11];
      enq_mix = '{60, 80, 92};
      market_mix = '{50, 15, 85};
      caps = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd127, 7'd3, 7'd65, 7'd0, 7'd63, 7'd5, 7'd0};
      caps[7] = 7'($urandom_range(1, 8));
      caps[10] = 7'($urandom_range(0, 127));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // stopped after reset: enqueue refused, empty dequeue, spare kind, flush
      issue(KIND_ENQUEUE, CLASS_TRADE, 32'hFFFF_FFFF);
      issue(KIND_DEQUEUE, CLASS_TICK, 32'h0);
      issue(KIND_UNUSED, CLASS_TRADE, 32'hFFFF_FFFF);
      issue(KIND_FLUSH, CLASS_TICK, 32'h0);
      settle();
      write_reg(CSR_CAPACITY, 7'd2);
      write_reg(CSR_ACCEPTING, 7'd1);

      // drop tick, then bar, then refuse when only orders and trades remain
      issue(KIND_ENQUEUE, CLASS_TICK, 32'h0);
      issue(KIND_ENQUEUE, CLASS_ORDER, 32'hFFFF_FFFF);
      issue(KIND_ENQUEUE, CLASS_BAR, 32'h5A5A_5A5A);
      issue(KIND_ENQUEUE, CLASS_TRADE, 32'hA5A5_A5A5);
      issue(KIND_ENQUEUE, CLASS_TICK, 32'h1234_5678);
      issue(KIND_DEQUEUE, CLASS_TICK, 32'h0);
      issue(KIND_DEQUEUE, CLASS_TICK, 32'h0);
      issue(KIND_DEQUEUE, CLASS_TICK, 32'h0);
      issue(KIND_ENQUEUE, CLASS_BAR, 32'h8000_0001);
      issue(KIND_ENQUEUE, CLASS_TICK, 32'h7FFF_FFFE);
      issue(KIND_FLUSH, CLASS_TICK, 32'h0);
      issue(KIND_DEQUEUE, CLASS_TICK, 32'h0);
      settle();

      // lower capacity beneath the fill
      write_reg(CSR_CAPACITY, 7'd0);
      issue(KIND_ENQUEUE, CLASS_TICK, 32'h0000_0011);
      issue(KIND_ENQUEUE, CLASS_BAR, 32'h0000_0022);
      issue(KIND_ENQUEUE, CLASS_ORDER, 32'h0000_0033);
      issue(KIND_ENQUEUE, CLASS_TRADE, 32'h0000_0044);
      settle();
      write_reg(CSR_CAPACITY, 7'd2);
      issue(KIND_ENQUEUE, CLASS_ORDER, 32'hDEAD_BEEF);
      issue(KIND_ENQUEUE, CLASS_TRADE, 32'hCAFE_F00D);
      issue(KIND_ENQUEUE, CLASS_TRADE, 32'h0BAD_F00D);
      settle();

      // stopping keeps the contents; dequeue still drains
      write_reg(CSR_ACCEPTING, 7'd0);
      issue(KIND_ENQUEUE, CLASS_TICK, 32'h1);
      issue(KIND_DEQUEUE, CLASS_TICK, 32'h0);
      issue(KIND_FLUSH, CLASS_TICK, 32'h0);
      settle();

      for (int phase = 0; phase < 11; phase++) begin
         write_reg(CSR_CAPACITY, caps[phase]);
         write_reg(CSR_ACCEPTING, (phase == 5) ? 7'd0 : 7'd1);
         no_idle = (phase % 3 == 1);
         if (phase == 5) begin
            run_phase(40, 30, 50);
         end else begin
            run_phase(127, enq_mix[phase % 3], market_mix[(phase / 3) % 3]);
         end
         settle();
      end

      $display("%0d commands issued, %0d result beats checked, peak fill %0d",
               mirror.commands, mirror.checked, mirror.max_fill);
      $display("%0d market events dropped, %0d enqueues refused, %0d dequeues served",
               mirror.drops, mirror.refusals, mirror.served);
      if (mirror.fails == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/bevq_pkg.sv
rtl/bevq_cell.sv
rtl/bevq_scan.sv
rtl/bounded_event_queue_drop_oldest_market.sv
tb/tb_bounded_event_queue_drop_oldest_market.sv
